FILE: src/xkt_pkg.sv
// ----------------------------------------------------------------------------
// xkt_pkg
// Shared constants and types for the repeating-key xor trial checker.
// ----------------------------------------------------------------------------
`default_nettype none

package xkt_pkg;

    localparam int MAX_TEXT = 4096;
    localparam int MAX_KEY  = 8;

    // byte counter must be able to hold MAX_TEXT itself
    localparam int CNT_W  = $clog2(MAX_TEXT + 1);
    // room for 9 * space count
    localparam int PROD_W = CNT_W + 4;

    localparam int KEY_W     = 64;
    localparam int KEY_LEN_W = 4;
    localparam int KEY_POS_W = 3;

    // configuration register indexes
    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    // characters of interest
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_CASE    = 8'h20;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_M       = 8'h6D;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_Y       = 8'h79;
    localparam logic [7:0] CH_Z       = 8'h7A;

    // words_found bit positions
    localparam int WORD_NEM  = 0;
    localparam int WORD_HOGY = 1;
    localparam int WORD_AZ   = 2;
    localparam int WORD_HA   = 3;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       last_byte;
    } xkt_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key_bytes;
        logic [KEY_LEN_W-1:0] key_len;   // already clamped to 1..MAX_KEY
    } xkt_cfg_t;

endpackage

`default_nettype wire

FILE: src/xkt_cfg_regs.sv
// ----------------------------------------------------------------------------
// xkt_cfg_regs
// Key configuration registers; the key length is clamped as it is written.
// ----------------------------------------------------------------------------
`default_nettype none

module xkt_cfg_regs
    import xkt_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_index,
    input  wire logic [KEY_W-1:0]     cfg_data,
    output xkt_cfg_t                  cfg
);

    logic [KEY_W-1:0]     key_bytes_reg;
    logic [KEY_LEN_W-1:0] key_len_reg;
    logic [KEY_LEN_W-1:0] len_raw;
    logic [KEY_LEN_W-1:0] len_clamped;

    assign len_raw = cfg_data[KEY_LEN_W-1:0];

    always_comb
    begin
        priority if (len_raw == '0)
        begin
            len_clamped = KEY_LEN_W'(1);
        end
        else if (len_raw > KEY_LEN_W'(MAX_KEY))
        begin
            len_clamped = KEY_LEN_W'(MAX_KEY);
        end
        else
        begin
            len_clamped = len_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= '0;
            key_len_reg   <= KEY_LEN_W'(MAX_KEY);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KEY_BYTES:  key_bytes_reg <= cfg_data;
                CFG_KEY_LENGTH: key_len_reg   <= len_clamped;
                default:        key_len_reg   <= key_len_reg;
            endcase
        end
    end

    assign cfg.key_bytes = key_bytes_reg;
    assign cfg.key_len   = key_len_reg;

endmodule

`default_nettype wire

FILE: src/xkt_input_stage.sv
// ----------------------------------------------------------------------------
// xkt_input_stage
// Input register; holds one request until the result stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module xkt_input_stage
    import xkt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] cipher_byte,
    input  wire logic       last_byte,
    output logic            item_valid,
    output xkt_item_t       item,
    input  wire logic       item_take
);

    logic      valid_reg;
    xkt_item_t item_reg;
    logic      load;

    // free when empty or when the held request moves on this cycle
    assign in_stall = valid_reg && !item_take;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cipher_byte <= cipher_byte;
            item_reg.last_byte   <= last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: src/xkt_core.sv
// ----------------------------------------------------------------------------
// xkt_core
// Decrypt, word scan, counters and verdict, ending in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xkt_core
    import xkt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire xkt_cfg_t   cfg,
    input  wire logic       item_valid,
    input  wire xkt_item_t  item,
    output logic            item_take,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      plain_byte,
    output logic            verdict_valid,
    output logic            plausible
);

    logic [KEY_POS_W-1:0] key_pos_reg,   key_pos_next;
    logic [CNT_W-1:0]     byte_cnt_reg,  byte_cnt_next;
    logic [CNT_W-1:0]     space_cnt_reg, space_cnt_next;
    logic [23:0]          recent_reg,    recent_next;
    logic [3:0]           words_reg,     words_next;

    logic                 out_valid_reg;
    logic [7:0]           plain_reg;
    logic                 verdict_reg;
    logic                 plausible_reg;

    logic [7:0]           key_byte;
    logic [7:0]           p;
    logic [7:0]           low;
    logic                 counting;
    logic [7:0]           b1, b2, b3;
    logic [3:0]           words_upd;
    logic [CNT_W-1:0]     byte_cnt_upd;
    logic [CNT_W-1:0]     space_cnt_upd;
    logic [PROD_W-1:0]    sp_ext, len_ext, sp_x6, sp_x9;
    logic                 pass;

    assign item_take = item_valid && (!out_valid_reg || !out_stall);

    assign key_byte = cfg.key_bytes[{key_pos_reg, 3'b000} +: 8];
    assign p        = item.cipher_byte ^ key_byte;
    assign low      = (p >= CH_UPPER_A && p <= CH_UPPER_Z) ? (p + CH_CASE) : p;
    assign counting = byte_cnt_reg < CNT_W'(MAX_TEXT);

    assign b1 = recent_reg[7:0];
    assign b2 = recent_reg[15:8];
    assign b3 = recent_reg[23:16];

    always_comb
    begin
        words_upd     = words_reg;
        byte_cnt_upd  = byte_cnt_reg;
        space_cnt_upd = space_cnt_reg;
        recent_next   = recent_reg;
        if (counting)
        begin
            if (b2 == CH_N && b1 == CH_E && low == CH_M)
            begin
                words_upd[WORD_NEM] = 1'b1;
            end
            if (b3 == CH_H && b2 == CH_O && b1 == CH_G && low == CH_Y)
            begin
                words_upd[WORD_HOGY] = 1'b1;
            end
            if (b1 == CH_A && low == CH_Z)
            begin
                words_upd[WORD_AZ] = 1'b1;
            end
            if (b1 == CH_H && low == CH_A)
            begin
                words_upd[WORD_HA] = 1'b1;
            end
            recent_next  = {recent_reg[15:0], low};
            byte_cnt_upd = byte_cnt_reg + CNT_W'(1);
            if (p == CH_SPACE)
            begin
                space_cnt_upd = space_cnt_reg + CNT_W'(1);
            end
        end
    end

    // 6 * spaces < length < 9 * spaces, as shifts and adds
    assign sp_ext  = PROD_W'(space_cnt_upd);
    assign len_ext = PROD_W'(byte_cnt_upd);
    assign sp_x6   = (sp_ext << 2) + (sp_ext << 1);
    assign sp_x9   = (sp_ext << 3) + sp_ext;
    assign pass    = (words_upd == 4'hF) && (sp_x6 < len_ext) && (len_ext < sp_x9);

    always_comb
    begin
        if ((KEY_LEN_W'(key_pos_reg) + KEY_LEN_W'(1)) >= cfg.key_len)
        begin
            key_pos_next = '0;
        end
        else
        begin
            key_pos_next = key_pos_reg + KEY_POS_W'(1);
        end
        byte_cnt_next  = byte_cnt_upd;
        space_cnt_next = space_cnt_upd;
        words_next     = words_upd;
        // end of message clears everything for the next one
        if (item.last_byte)
        begin
            key_pos_next   = '0;
            byte_cnt_next  = '0;
            space_cnt_next = '0;
            words_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg   <= '0;
            byte_cnt_reg  <= '0;
            space_cnt_reg <= '0;
            recent_reg    <= '0;
            words_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                key_pos_reg   <= key_pos_next;
                byte_cnt_reg  <= byte_cnt_next;
                space_cnt_reg <= space_cnt_next;
                recent_reg    <= item.last_byte ? 24'h0 : recent_next;
                words_reg     <= words_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            plain_reg     <= p;
            verdict_reg   <= item.last_byte;
            plausible_reg <= item.last_byte && pass;
        end
    end

    assign out_valid     = out_valid_reg;
    assign plain_byte    = plain_reg;
    assign verdict_valid = verdict_reg;
    assign plausible     = plausible_reg;

endmodule

`default_nettype wire

FILE: src/xor_key_trial_checker.sv
// path: an accepted request waits in the input register, then moves on into the result
// register, where it shows on out_valid
// throughput: one byte per cycle; the input register and the result register
// form a two-stage pipeline that only stops while out_stall holds a result
// reset: rst_n clears the pipeline valids, key position, counters and word flags;
// the key resets to zero and the key length to eight
// ----------------------------------------------------------------------------
// xor_key_trial_checker
// Repeating-key xor decrypter with a word and space plausibility verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_key_trial_checker
    import xkt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       cipher_byte,
    input  wire logic             last_byte,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [7:0]            plain_byte,
    output logic                  verdict_valid,
    output logic                  plausible,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_index,
    input  wire logic [KEY_W-1:0] cfg_data
);

    xkt_cfg_t  cfg;
    xkt_item_t item;
    logic      item_valid;
    logic      item_take;

    assign cfg_ready = 1'b1;

    xkt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    xkt_input_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cipher_byte (cipher_byte),
        .last_byte   (last_byte),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    xkt_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plain_byte    (plain_byte),
        .verdict_valid (verdict_valid),
        .plausible     (plausible)
    );

endmodule

`default_nettype wire

FILE: src/xkt_checker.sv
// ----------------------------------------------------------------------------
// xkt_checker
// Port-level assertions for the trial checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module xkt_checker
    import xkt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_stall,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire logic [7:0]       plain_byte,
    input  wire logic             verdict_valid,
    input  wire logic             plausible,
    input  wire logic             cfg_ready
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(plain_byte)
            && $stable(verdict_valid) && $stable(plausible))
        else $error("result changed while stalled");

    // a verdict of plausible only comes with the final byte
    a_plaus_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && plausible |-> verdict_valid)
        else $error("plausible without verdict");

    // the input side only backs up when the output side does
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with output free");

    // an idle pipeline never stalls its input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind xor_key_trial_checker xkt_checker u_xkt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .plain_byte    (plain_byte),
    .verdict_valid (verdict_valid),
    .plausible     (plausible),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

FILE: verif/xkt_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xkt_result_checker
// Watches the request, result and register channels of the xor trial checker,
// keeps its own copy of the key and message state, predicts every result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------

module xkt_result_checker
    import xkt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic [7:0]       cipher_byte,
    input  logic             last_byte,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [7:0]       plain_byte,
    input  logic             verdict_valid,
    input  logic             plausible,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [KEY_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [7:0] plain_byte;
        logic       verdict_valid;
        logic       plausible;
    } decrypt_result_t;

    decrypt_result_t      plain_expected_q[$];

    logic [KEY_W-1:0]     key_bytes_q;
    logic [KEY_LEN_W-1:0] key_length_q;
    logic [KEY_POS_W-1:0] key_pos;
    logic [CNT_W-1:0]     byte_cnt;
    logic [CNT_W-1:0]     space_cnt;
    logic [23:0]          recent_lower;
    logic [3:0]           words_seen;

    function automatic decrypt_result_t decrypt_byte(input logic [7:0] cipher,
                                                     input logic last);
        logic [7:0]      key_byte;
        logic [7:0]      plain;
        logic [7:0]      lower;
        int              key_len;
        decrypt_result_t res;
        key_byte = key_bytes_q[8*key_pos +: 8];
        plain    = cipher ^ key_byte;
        key_len  = (key_length_q == 0) ? 1 :
                   (key_length_q > MAX_KEY) ? MAX_KEY : int'(key_length_q);
        res.plain_byte    = plain;
        res.verdict_valid = last;
        res.plausible     = 1'b0;

        // bytes past the text limit are decrypted but neither counted nor scanned
        if (byte_cnt < MAX_TEXT) begin
            lower = (plain >= CH_UPPER_A && plain <= CH_UPPER_Z) ? plain + CH_CASE : plain;
            if (recent_lower[15:8] == CH_N && recent_lower[7:0] == CH_E && lower == CH_M)
                words_seen[WORD_NEM] = 1'b1;
            if (recent_lower[23:16] == CH_H && recent_lower[15:8] == CH_O &&
                recent_lower[7:0] == CH_G && lower == CH_Y)
                words_seen[WORD_HOGY] = 1'b1;
            if (recent_lower[7:0] == CH_A && lower == CH_Z)
                words_seen[WORD_AZ] = 1'b1;
            if (recent_lower[7:0] == CH_H && lower == CH_A)
                words_seen[WORD_HA] = 1'b1;
            recent_lower = {recent_lower[15:0], lower};
            if (plain == CH_SPACE)
                space_cnt = space_cnt + 1'b1;
            byte_cnt = byte_cnt + 1'b1;
        end

        key_pos = (int'(key_pos) + 1 >= key_len) ? '0 : key_pos + 1'b1;

        if (last) begin
            if (&words_seen && 6 * int'(space_cnt) < int'(byte_cnt) &&
                int'(byte_cnt) < 9 * int'(space_cnt))
                res.plausible = 1'b1;
            key_pos      = '0;
            byte_cnt     = '0;
            space_cnt    = '0;
            recent_lower = '0;
            words_seen   = '0;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        decrypt_result_t want;
        if (!rst_n)
        begin
            plain_expected_q.delete();
            key_bytes_q  = '0;
            key_length_q = 4'd8;
            key_pos      = '0;
            byte_cnt     = '0;
            space_cnt    = '0;
            recent_lower = '0;
            words_seen   = '0;
            fail_count   = 0;
            pending      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (plain_expected_q.size() == 0)
                begin
                    $error("unexpected result: plain_byte %h with no request waiting",
                           plain_byte);
                    fail_count++;
                end
                else
                begin
                    want = plain_expected_q.pop_front();
                    if (plain_byte !== want.plain_byte)
                    begin
                        $error("plain_byte: expected %h, got %h", want.plain_byte, plain_byte);
                        fail_count++;
                    end
                    if (verdict_valid !== want.verdict_valid)
                    begin
                        $error("verdict_valid: expected %b, got %b",
                               want.verdict_valid, verdict_valid);
                        fail_count++;
                    end
                    if (plausible !== want.plausible)
                    begin
                        $error("plausible: expected %b, got %b", want.plausible, plausible);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
                plain_expected_q.push_back(decrypt_byte(cipher_byte, last_byte));

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_KEY_BYTES)
                    key_bytes_q = cfg_data;
                else
                    key_length_q = cfg_data[KEY_LEN_W-1:0];
            end

            pending = plain_expected_q.size();
        end
    end

endmodule

FILE: verif/xor_key_trial_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_key_trial_checker_tb
// Feeds ciphertext messages through the xor trial checker under changing keys
// and key lengths, with random gaps and stalls on both channels, and reports
// the verdict of the result checker.
// ----------------------------------------------------------------------------

module xor_key_trial_checker_tb;
    import xkt_pkg::*;

    localparam int ITEMS       = 1000;
    localparam int STUCK_LIMIT = 3000;
    localparam int HOLD_CYCLES = 120;

    typedef enum int {
        TEXT_GOOD,
        TEXT_MISSING_WORD,
        TEXT_DENSE,
        TEXT_SPARSE,
        TEXT_NOISE
    } text_style_e;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       cipher_byte;
    logic             last_byte;
    logic             out_valid;
    logic             out_stall;
    logic [7:0]       plain_byte;
    logic             verdict_valid;
    logic             plausible;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_index;
    logic [KEY_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int stuck_cycles = 0;

    // idling limits and the long receiver hold-off, set per phase
    int tx_max  = 0;
    int rx_max  = 0;
    int rx_hold = 0;

    // register copies used to encrypt the plaintext we want the block to see
    logic [KEY_W-1:0]     key_cfg;
    logic [KEY_LEN_W-1:0] len_cfg;
    int                   tx_pos;
    logic [7:0]           text_q[$];

    always #5 clk = ~clk;

    xor_key_trial_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cipher_byte   (cipher_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plain_byte    (plain_byte),
        .verdict_valid (verdict_valid),
        .plausible     (plausible),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    xkt_result_checker u_result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cipher_byte   (cipher_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .plain_byte    (plain_byte),
        .verdict_valid (verdict_valid),
        .plausible     (plausible),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stall before each result, one long hold-off on request
    initial
    begin : receiver
        int wait_cycles;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            wait_cycles = $urandom_range(0, rx_max);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic int eff_key_len();
        if (len_cfg == 0)
            return 1;
        if (len_cfg > MAX_KEY)
            return MAX_KEY;
        return int'(len_cfg);
    endfunction

    // one request; in_valid stays high on return so the next byte can follow directly
    task automatic send_byte(input logic [7:0] plain, input logic last);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cipher_byte <= plain ^ key_cfg[8*tx_pos +: 8];
        last_byte   <= last;
        tx_pos = (last || tx_pos + 1 >= eff_key_len()) ? 0 : tx_pos + 1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_text(input logic last_at_end);
        foreach (text_q[i])
            send_byte(text_q[i], last_at_end && i == text_q.size() - 1);
    endtask

    task automatic write_reg(input logic idx, input logic [KEY_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_KEY_BYTES)
            key_cfg = data;
        else
            len_cfg = data[KEY_LEN_W-1:0];
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic add_word(input string w, input bit mix_case);
        logic [7:0] ch;
        for (int i = 0; i < w.len(); i++)
        begin
            ch = w[i];
            if (mix_case && ch >= CH_A && ch <= CH_Z && $urandom_range(0, 1) == 1)
                ch = ch - CH_CASE;
            text_q.push_back(ch);
        end
    endtask

    // appends a space separated message (noise style: random bytes); fillers set the bytes-per-space ratio
    task automatic build_text(input text_style_e style);
        string      key_words[4];
        int         tokens[$];
        int         fill_lo;
        int         fill_hi;
        int         skip;
        logic [7:0] ch;
        key_words = '{"nem", "hogy", "az", "ha"};
        if (style == TEXT_NOISE)
        begin
            repeat ($urandom_range(1, 24))
                text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        fill_lo = (style == TEXT_DENSE) ? 1 : (style == TEXT_SPARSE) ? 10 : 5;
        fill_hi = (style == TEXT_DENSE) ? 3 : (style == TEXT_SPARSE) ? 20 : 11;
        skip    = (style == TEXT_MISSING_WORD) ? $urandom_range(0, 3) : -1;
        repeat ($urandom_range(4, 10))
            tokens.push_back(-1);
        for (int k = 0; k < 4; k++)
            if (k != skip)
                tokens.insert($urandom_range(0, tokens.size()), k);
        foreach (tokens[t])
        begin
            if (t > 0)
                text_q.push_back(CH_SPACE);
            if (tokens[t] >= 0)
                add_word(key_words[tokens[t]], 1'b1);
            else
                repeat ($urandom_range(fill_lo, fill_hi))
                begin
                    ch = CH_A + 8'($urandom_range(0, 25));
                    if ($urandom_range(0, 1) == 1)
                        ch = ch - CH_CASE;
                    text_q.push_back(ch);
                end
        end
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 14;
        endcase
    endfunction

    initial
    begin : stimulus
        int          rand_items;
        int          phase;
        text_style_e style;
        logic [KEY_W-1:0] key_pick;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cipher_byte = '0;
        last_byte   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_KEY_BYTES;
        cfg_data    = '0;
        key_cfg     = '0;
        len_cfg     = 4'd8;
        tx_pos      = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset key: byte extremes, two byte message without spaces
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // all-ones key, mixed case words behind a zero byte, ratio inside the window
        settle();
        write_reg(CFG_KEY_BYTES, {KEY_W{1'b1}});
        cfg_valid <= 1'b0;
        text_q.delete();
        text_q.push_back(8'h00);
        add_word("NeM hOgY aZHa", 1'b0);
        send_text(1'b1);

        // key length zero, then above the limit while the message is still open
        settle();
        write_reg(CFG_KEY_BYTES, {$urandom, $urandom});
        write_reg(CFG_KEY_LENGTH, 64'(0));
        cfg_valid <= 1'b0;
        repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
        settle();
        write_reg(CFG_KEY_LENGTH, 64'(15));
        cfg_valid <= 1'b0;
        send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);

        rand_items = 0;
        phase = 0;
        while (rand_items < ITEMS)
        begin
            settle();
            if (phase == 0 || $urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       key_pick = '0;
                    1:       key_pick = {KEY_W{1'b1}};
                    default: key_pick = {$urandom, $urandom};
                endcase
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_KEY_BYTES, key_pick);
                write_reg(CFG_KEY_LENGTH, ($urandom_range(0, 4) == 0) ?
                          64'($urandom_range(0, 15)) : 64'($urandom_range(1, 8)));
                write_reg(CFG_KEY_BYTES, key_pick);
                cfg_valid <= 1'b0;
            end
            tx_max = pick_idle();
            rx_max = pick_idle();
            text_q.delete();

            if (phase == 1)
            begin
                // receiver holds off while requests keep coming back to back
                tx_max  = 0;
                rx_hold = HOLD_CYCLES;
                build_text(TEXT_GOOD);
                text_q.push_back(CH_SPACE);
                build_text(TEXT_GOOD);
                send_text(1'b1);
                rand_items += text_q.size();
            end
            else if (phase == 3)
            begin
                // one message past the text limit, tail is decrypted but not counted
                tx_max = 0;
                rx_max = 0;
                while (text_q.size() < MAX_TEXT + 64)
                begin
                    build_text(TEXT_GOOD);
                    text_q.push_back(CH_SPACE);
                end
                send_text(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    case ($urandom_range(0, 9))
                        6:       style = TEXT_MISSING_WORD;
                        7:       style = TEXT_DENSE;
                        8:       style = TEXT_SPARSE;
                        9:       style = TEXT_NOISE;
                        default: style = TEXT_GOOD;
                    endcase
                    text_q.delete();
                    build_text(style);
                    send_text(1'b1);
                    rand_items += text_q.size();
                end
            end
            phase++;
        end

        settle();
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
